FILE: hw/rtl/evad_pkg.sv
// ----------------------------------------------------------------------------
// Energy VAD package
// Shared widths, codes, item types and status structs of the energy voice
// activity detector.
// ----------------------------------------------------------------------------
package evad_pkg;

    // Packet length limit; samples past it are not counted
    localparam int MAX_PACKET_SAMPLES = 16384;

    localparam int SAMPLE_W   = 32;
    localparam int MAG_W      = 17;
    localparam int TIME_W     = 48;
    localparam int THR_W      = 17;
    localparam int SPAN_W     = 32;
    localparam int FMT_W      = 2;
    localparam int KIND_W     = 2;
    localparam int CTR_W      = 32;
    localparam int CNT_W      = $clog2(MAX_PACKET_SAMPLES + 1);
    localparam int SUM_W      = MAG_W + $clog2(MAX_PACKET_SAMPLES);
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Sample formats
    localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SILENCE_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL  = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_present;
        logic                       last_of_packet;
        logic [TIME_W-1:0]          packet_time;
    } evad_in_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic              speech_active;
        logic [MAG_W-1:0]  packet_level;
        logic [MAG_W-1:0]  packet_peak;
        logic [TIME_W-1:0] event_time;
        logic [CTR_W-1:0]  packet_number;
        logic [CTR_W-1:0]  events_sent;
    } evad_out_t;

    // Accumulator status handed from the front end to the sequencer
    typedef struct packed {
        logic              last_pend;
        logic [SUM_W-1:0]  sum;
        logic [MAG_W-1:0]  peak;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] packet_time;
    } evad_acc_t;

endpackage

FILE: hw/rtl/evad_in_if.sv
// ----------------------------------------------------------------------------
// Energy VAD sample channel
// Valid/ready channel that carries one input item per transfer.
// ----------------------------------------------------------------------------
interface evad_in_if
    import evad_pkg::*;
    ();
    logic     valid;
    logic     ready;
    evad_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/evad_out_if.sv
// ----------------------------------------------------------------------------
// Energy VAD event channel
// Valid/ready channel that carries one speech event per transfer.
// ----------------------------------------------------------------------------
interface evad_out_if
    import evad_pkg::*;
    ();
    logic      valid;
    logic      ready;
    evad_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/energy_voice_activity_detector.sv
// ----------------------------------------------------------------------------
// Energy voice activity detector
// Per-packet level and peak, hysteresis speech state with silence hangover
// and periodic update events.
// ----------------------------------------------------------------------------
// Ready stays high while a packet fills. The last item of a packet holds
// ready low while the packet is closed: the front end accumulates it, the
// sequencer loads the divider, the bit-serial divider works through the
// SUM_W (31) dividend bits and raises its done flag, then come the silence
// check, the update check if reached and the hand-over of any event to the
// output register. An empty packet skips the divider and the checks. The
// output register holds an event while new samples keep coming in; the
// block only waits when a second event is ready before the first is taken.
module energy_voice_activity_detector
    import evad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    evad_in_if.sink               samples,
    evad_out_if.source            events
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SIL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;

    // Configuration registers
    logic [FMT_W-1:0]  fmt_reg;
    logic [THR_W-1:0]  start_thr_reg;
    logic [THR_W-1:0]  stop_thr_reg;
    logic [SPAN_W-1:0] min_sil_reg;
    logic [SPAN_W-1:0] upd_int_reg;

    // Detector state
    logic              active_reg, active_next;
    logic [TIME_W-1:0] silence_since_reg, silence_since_next;
    logic [TIME_W-1:0] last_update_reg, last_update_next;
    logic [CTR_W-1:0]  packets_seen_reg, packets_seen_next;
    logic [CTR_W-1:0]  events_emitted_reg, events_emitted_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [MAG_W-1:0]  level_reg, level_next;
    logic [MAG_W-1:0]  peak_reg, peak_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    evad_out_t         out_data_reg, out_data_next;

    evad_acc_t         acc;
    logic              accept;
    logic              clear;
    logic              div_start;
    logic              div_done;
    logic [MAG_W-1:0]  div_quo;

    logic [TIME_W-1:0] now;
    logic [THR_W-1:0]  eff_start;
    logic [TIME_W-1:0] since_eff;
    logic [TIME_W-1:0] el_since;
    logic [SPAN_W-1:0] el_span;
    logic [TIME_W:0]   el_diff;
    logic              el_ok;
    logic              out_free;

    assign accept        = samples.valid && samples.ready;
    assign samples.ready = (state_reg == S_IDLE) && !acc.last_pend;
    assign clear         = (state_reg == S_LOAD);
    assign div_start     = (state_reg == S_LOAD) && (acc.count != '0);
    assign now           = acc.packet_time;
    assign out_free      = !out_valid_reg || events.ready;

    evad_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (samples.data),
        .fmt    (fmt_reg),
        .clear  (clear),
        .acc    (acc)
    );

    evad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc.sum),
        .divisor  (acc.count),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_S16;
            start_thr_reg <= '0;
            stop_thr_reg  <= '0;
            min_sil_reg   <= '0;
            upd_int_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_FORMAT:    fmt_reg       <= cfg_data[FMT_W-1:0];
                REG_START_THRESHOLD:  start_thr_reg <= cfg_data[THR_W-1:0];
                REG_STOP_THRESHOLD:   stop_thr_reg  <= cfg_data[THR_W-1:0];
                REG_MIN_SILENCE_TIME: min_sil_reg   <= cfg_data[SPAN_W-1:0];
                REG_UPDATE_INTERVAL:  upd_int_reg   <= cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective start threshold and silence start point
    assign eff_start = (start_thr_reg > stop_thr_reg) ? start_thr_reg : stop_thr_reg;
    assign since_eff = (silence_since_reg == '0) ? now : silence_since_reg;

    // Shared elapsed-time unit: silence hangover in S_SIL, update interval else
    assign el_since = (state_reg == S_SIL) ? since_eff : last_update_reg;
    assign el_span  = (state_reg == S_SIL) ? min_sil_reg : upd_int_reg;
    assign el_diff  = {1'b0, now} - {1'b0, el_since};
    assign el_ok    = (el_span == '0) ||
                      (!el_diff[TIME_W] &&
                       (el_diff[TIME_W-1:0] >= {{(TIME_W - SPAN_W){1'b0}}, el_span}));

    // Sequence one packet close
    always_comb
    begin
        state_next          = state_reg;
        active_next         = active_reg;
        silence_since_next  = silence_since_reg;
        last_update_next    = last_update_reg;
        packets_seen_next   = packets_seen_reg;
        events_emitted_next = events_emitted_reg;
        kind_next           = kind_reg;
        level_next          = level_reg;
        peak_next           = peak_reg;
        out_valid_next      = out_valid_reg;
        out_data_next       = out_data_reg;

        // Release the output register on a transfer
        if (events.valid && events.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc.last_pend)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                packets_seen_next = packets_seen_reg + 1'b1;
                peak_next         = acc.peak;
                state_next        = (acc.count != '0) ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    level_next = div_quo;
                    state_next = S_SIL;
                end
            end
            S_SIL:
            begin
                if (!active_reg)
                begin
                    if (level_reg >= eff_start)
                    begin
                        active_next        = 1'b1;
                        silence_since_next = '0;
                        last_update_next   = now;
                        kind_next          = KIND_START;
                        state_next         = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (level_reg < stop_thr_reg)
                begin
                    silence_since_next = since_eff;
                    if (el_ok)
                    begin
                        active_next        = 1'b0;
                        silence_since_next = '0;
                        last_update_next   = now;
                        kind_next          = KIND_END;
                        state_next         = S_OUT;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
                else
                begin
                    silence_since_next = '0;
                    state_next         = S_UPD;
                end
            end
            S_UPD:
            begin
                if (el_ok)
                begin
                    last_update_next = now;
                    kind_next        = KIND_UPDATE;
                    state_next       = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.event_kind    = kind_reg;
                    out_data_next.speech_active = (kind_reg != KIND_END);
                    out_data_next.packet_level  = level_reg;
                    out_data_next.packet_peak   = peak_reg;
                    out_data_next.event_time    = now;
                    out_data_next.packet_number = packets_seen_reg;
                    out_data_next.events_sent   = events_emitted_reg;
                    events_emitted_next         = events_emitted_reg + 1'b1;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            active_reg         <= 1'b0;
            silence_since_reg  <= '0;
            last_update_reg    <= '0;
            packets_seen_reg   <= '0;
            events_emitted_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            active_reg         <= active_next;
            silence_since_reg  <= silence_since_next;
            last_update_reg    <= last_update_next;
            packets_seen_reg   <= packets_seen_next;
            events_emitted_reg <= events_emitted_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Packet results and event payload, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        level_reg    <= level_next;
        peak_reg     <= peak_next;
        out_data_reg <= out_data_next;
    end

    assign events.valid = out_valid_reg;
    assign events.data  = out_data_reg;

`ifndef SYNTHESIS
    // Closing a packet blocks the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.data.last_of_packet) |=> !samples.ready)
    else $error("item taken while a packet was being closed");

    // A waiting event is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !events.ready)
            |=> (state_reg == S_OUT && $stable(out_data_reg)))
    else $error("pending event overwritten");

    // The divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
    else $error("divider result arrived outside the divide step");

    // Speech ends only with an end event on its way out
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> (state_reg == S_OUT && kind_reg == KIND_END))
    else $error("speech ended without an end event");

    // The event counter moves only when an event is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (events_emitted_reg != $past(events_emitted_reg))
            |-> ($past(state_reg) == S_OUT && out_valid_reg))
    else $error("event count moved without an event");
`endif

endmodule

FILE: hw/rtl/evad_front.sv
// ----------------------------------------------------------------------------
// Energy VAD front end
// Normalises each sample to a Q1.16 magnitude, then accumulates the packet's
// magnitude sum, peak and sample count one stage later.
// ----------------------------------------------------------------------------
module evad_front
    import evad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  evad_in_t         item,
    input  logic [FMT_W-1:0] fmt,
    input  logic             clear,
    output evad_acc_t        acc
);

    logic              pm_valid_reg, pm_valid_next;
    logic [MAG_W-1:0]  pm_mag_reg;
    logic              last_pend_reg, last_pend_next;
    logic [TIME_W-1:0] time_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [MAG_W-1:0]  peak_reg, peak_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MAG_W-1:0]  mag;

    // Normalise a raw sample to an unsigned Q1.16 magnitude
    function automatic logic [MAG_W-1:0] magnitude_of(
        input logic [SAMPLE_W-1:0] raw,
        input logic [FMT_W-1:0]    f
    );
        logic [7:0]  d8;
        logic [16:0] a16;
        logic [32:0] a32;
        logic [MAG_W-1:0] m;
        d8  = raw[7] ? {1'b0, raw[6:0]} : (8'd128 - raw[7:0]);
        a16 = raw[15] ? (17'h10000 - {1'b0, raw[15:0]}) : {1'b0, raw[15:0]};
        a32 = raw[31] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
        unique case (f)
            FMT_U8:  m = {d8, 9'b0};
            FMT_S16: m = {a16[15:0], 1'b0};
            default: m = a32[31:15];
        endcase
        return m;
    endfunction

    assign mag = magnitude_of(item.sample, fmt);

    // Stage the magnitude of an accepted sample and track the pending packet end
    always_comb
    begin
        pm_valid_next  = accept && item.sample_present && (fmt != 2'd3);
        last_pend_next = last_pend_reg;
        if (clear)
        begin
            last_pend_next = 1'b0;
        end
        if (accept && item.last_of_packet)
        begin
            last_pend_next = 1'b1;
        end
    end

    // Accumulate the staged magnitude; drop samples past the packet limit
    always_comb
    begin
        sum_next   = sum_reg;
        peak_next  = peak_reg;
        count_next = count_reg;
        if (clear)
        begin
            sum_next   = '0;
            peak_next  = '0;
            count_next = '0;
        end
        else if (pm_valid_reg && (count_reg < CNT_W'(MAX_PACKET_SAMPLES)))
        begin
            sum_next   = sum_reg + SUM_W'(pm_mag_reg);
            peak_next  = (pm_mag_reg > peak_reg) ? pm_mag_reg : peak_reg;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_valid_reg  <= 1'b0;
            last_pend_reg <= 1'b0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            pm_valid_reg  <= pm_valid_next;
            last_pend_reg <= last_pend_next;
            sum_reg       <= sum_next;
            peak_reg      <= peak_next;
            count_reg     <= count_next;
        end
    end

    // Payload staging, no reset needed
    always_ff @(posedge clk)
    begin
        pm_mag_reg <= mag;
        if (accept && item.last_of_packet)
        begin
            time_reg <= item.packet_time;
        end
    end

    assign acc.last_pend   = last_pend_reg;
    assign acc.sum         = sum_reg;
    assign acc.peak        = peak_reg;
    assign acc.count       = count_reg;
    assign acc.packet_time = time_reg;

endmodule

FILE: hw/rtl/evad_div.sv
// ----------------------------------------------------------------------------
// Energy VAD divider
// Restoring divider that works out one quotient bit per cycle: packet
// magnitude sum over sample count, truncated.
// ----------------------------------------------------------------------------
module evad_div
    import evad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [MAG_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W+1:0]     trial;

    // Trial subtract of the shifted remainder
    assign trial = {1'b0, rem_reg, quo_reg[SUM_W-1]} - {2'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(SUM_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[CNT_W+1])
            begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[CNT_W-2:0], quo_reg[SUM_W-1]};
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[MAG_W-1:0];

endmodule

FILE: tb/energy_voice_activity_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Energy voice activity detector testbench
// Drives sample items over the input channel and predicts every speech event
// with an independent model of the level, peak and hysteresis logic. Events
// from the output channel are compared field by field, in order, against the
// predicted ones. Directed tests cover format extremes, hangover corner cases
// and the packet length cap; random phases then sweep the configuration.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_tb;
    import evad_pkg::*;

    localparam logic [FMT_W-1:0] FMT_NONE = 2'd3;
    localparam int IDLE_CYCLES = 64;
    localparam int RANDOM_ITEMS = 1950;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    evad_in_if samples_ch ();
    evad_out_if events_ch ();

    energy_voice_activity_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .events    (events_ch)
    );

    // Detector copy: configuration
    logic [FMT_W-1:0] cfg_format;
    logic [THR_W-1:0] cfg_start;
    logic [THR_W-1:0] cfg_stop;
    logic [SPAN_W-1:0] cfg_silence;
    logic [SPAN_W-1:0] cfg_update;

    // Detector copy: packet accumulator and speech state
    logic [31:0] mag_total;
    logic [MAG_W-1:0] mag_peak;
    int unsigned mag_count;
    bit speaking;
    logic [TIME_W-1:0] quiet_since;
    logic [TIME_W-1:0] last_report;
    logic [CTR_W-1:0] packets_ended;
    logic [CTR_W-1:0] events_made;

    evad_out_t pending_events[$];

    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    bit gaps_on = 1'b1;
    int unsigned hold_cycles = 0;
    logic [TIME_W-1:0] now_us = 48'd1000;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Normalise one raw sample to a Q1.16 magnitude
    function automatic logic [MAG_W-1:0] sample_magnitude(logic [31:0] raw,
                                                          logic [FMT_W-1:0] f);
        logic [7:0] b;
        logic [15:0] h;
        logic [32:0] w;
        logic [MAG_W-1:0] d;
        case (f)
            FMT_U8:
            begin
                b = raw[7:0];
                d = (b >= 8'd128) ? MAG_W'(b - 8'd128) : MAG_W'(8'd128 - b);
                return MAG_W'(d * 512);
            end
            FMT_S16:
            begin
                h = raw[15:0];
                return h[15] ? MAG_W'((17'h10000 - h) * 2) : MAG_W'(h * 2);
            end
            default:
            begin
                w = raw[31] ? 33'h1_0000_0000 - {1'b0, raw} : {1'b0, raw};
                return MAG_W'(w >> 15);
            end
        endcase
    endfunction

    // A span of zero is always over; time running backwards never ends one
    function automatic bit span_passed(logic [TIME_W-1:0] stamp,
                                       logic [TIME_W-1:0] since,
                                       logic [SPAN_W-1:0] span);
        if (span == '0)
            return 1'b1;
        if (stamp < since)
            return 1'b0;
        return (stamp - since) >= TIME_W'(span);
    endfunction

    // Update the detector copy with one accepted item and queue any event
    task automatic advance_detector(input evad_in_t it);
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] level;
        logic [MAG_W-1:0] peak;
        logic [THR_W-1:0] gate;
        int unsigned count;
        bit ended;
        evad_out_t ev;
        if (it.sample_present && cfg_format != FMT_NONE && mag_count < MAX_PACKET_SAMPLES)
        begin
            mag = sample_magnitude(it.sample, cfg_format);
            mag_total += mag;
            if (mag > mag_peak)
                mag_peak = mag;
            mag_count++;
        end
        if (!it.last_of_packet)
            return;

        // Close the packet
        count = mag_count;
        level = (count != 0) ? MAG_W'(mag_total / count) : '0;
        peak = mag_peak;
        mag_total = '0;
        mag_peak = '0;
        mag_count = 0;
        packets_ended++;
        if (count == 0)
            return;

        gate = (cfg_start > cfg_stop) ? cfg_start : cfg_stop;
        if (!speaking)
        begin
            if (level < gate)
                return;
            speaking = 1'b1;
            quiet_since = '0;
            last_report = it.packet_time;
            ev.event_kind = KIND_START;
            ev.speech_active = 1'b1;
        end
        else
        begin
            ended = 1'b0;
            // Count silence from the first quiet packet; zero means unset
            if (level < cfg_stop)
            begin
                if (quiet_since == '0)
                    quiet_since = it.packet_time;
                if (span_passed(it.packet_time, quiet_since, cfg_silence))
                begin
                    speaking = 1'b0;
                    quiet_since = '0;
                    last_report = it.packet_time;
                    ended = 1'b1;
                end
            end
            else
            begin
                quiet_since = '0;
            end
            if (ended)
            begin
                ev.event_kind = KIND_END;
                ev.speech_active = 1'b0;
            end
            else if (span_passed(it.packet_time, last_report, cfg_update))
            begin
                last_report = it.packet_time;
                ev.event_kind = KIND_UPDATE;
                ev.speech_active = 1'b1;
            end
            else
            begin
                return;
            end
        end
        ev.packet_level = level;
        ev.packet_peak = peak;
        ev.event_time = it.packet_time;
        ev.packet_number = packets_ended;
        ev.events_sent = events_made;
        events_made++;
        pending_events.push_back(ev);
    endtask

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            errors++;
        end
    endfunction

    // Compare each event transfer with the oldest prediction
    always @(posedge clk)
    begin
        evad_out_t want;
        if (rst_n === 1'b1 && events_ch.valid === 1'b1 && events_ch.ready === 1'b1)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event with no prediction: kind %0d time %0d",
                       events_ch.data.event_kind, events_ch.data.event_time);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                check_field("event_kind", want.event_kind, events_ch.data.event_kind);
                check_field("speech_active", want.speech_active,
                            events_ch.data.speech_active);
                check_field("packet_level", want.packet_level, events_ch.data.packet_level);
                check_field("packet_peak", want.packet_peak, events_ch.data.packet_peak);
                check_field("event_time", want.event_time, events_ch.data.event_time);
                check_field("packet_number", want.packet_number,
                            events_ch.data.packet_number);
                check_field("events_sent", want.events_sent, events_ch.data.events_sent);
            end
        end
    end

    // Event receiver: stall in changing patterns, or hold off on request
    initial
    begin
        rx_mode_e mode;
        int unsigned mode_left;
        int unsigned tick;
        mode = RX_FREE;
        mode_left = 0;
        tick = 0;
        events_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_cycles > 0)
            begin
                events_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_FREE:     events_ch.ready <= 1'b1;
                    RX_HALF:     events_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   events_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: events_ch.ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    function automatic evad_in_t make_item(logic [31:0] raw, bit present, bit last,
                                           logic [TIME_W-1:0] stamp);
        evad_in_t it;
        it.sample = raw;
        it.sample_present = present;
        it.last_of_packet = last;
        it.packet_time = stamp;
        return it;
    endfunction

    // Offer one item in bursts with random gaps; hold it until transferred
    task automatic send_item(input evad_in_t it);
        @(negedge clk);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                samples_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.data <= it;
        do
            @(posedge clk);
        while (samples_ch.ready !== 1'b1);
        advance_detector(it);
        burst_left--;
        items_sent++;
    endtask

    // Drop valid, wait for every predicted event, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        samples_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SAMPLE_FORMAT:    cfg_format = value[FMT_W-1:0];
            REG_START_THRESHOLD:  cfg_start = value[THR_W-1:0];
            REG_STOP_THRESHOLD:   cfg_stop = value[THR_W-1:0];
            REG_MIN_SILENCE_TIME: cfg_silence = value;
            REG_UPDATE_INTERVAL:  cfg_update = value;
            default: ;
        endcase
    endtask

    // Raw sample of roughly the given magnitude, random sign and spare bits
    function automatic logic [31:0] raw_for_magnitude(int mag);
        logic [31:0] noise;
        logic [63:0] w;
        bit neg;
        int d;
        noise = $urandom;
        neg = $urandom_range(0, 1);
        case (cfg_format)
            FMT_U8:
            begin
                d = mag >> 9;
                if (d >= 128)
                    return {noise[31:8], 8'd0};
                return {noise[31:8], neg ? 8'(128 - d) : 8'(128 + d)};
            end
            FMT_S16:
            begin
                d = mag >> 1;
                if (d >= 32768)
                    return {noise[31:16], 16'h8000};
                return {noise[31:16], neg ? 16'(-d) : 16'(d)};
            end
            default:
            begin
                w = (64'(mag) << 15) | 64'(noise[14:0]);
                if (w >= 64'h8000_0000)
                    return 32'h8000_0000;
                return neg ? 32'(-w) : 32'(w);
            end
        endcase
    endfunction

    // One packet around a target magnitude; stray sample-less items mixed in
    task automatic send_packet(input int unsigned len, input int target, input int spread,
                               input bit noisy, input logic [TIME_W-1:0] stamp);
        logic [31:0] raw;
        logic [TIME_W-1:0] junk_time;
        int mag;
        bit last;
        for (int unsigned i = 0; i < len; i++)
        begin
            mag = target + $urandom_range(0, spread) - spread / 2;
            if (mag < 0)
                mag = 0;
            if (mag > 65536)
                mag = 65536;
            raw = noisy ? $urandom : raw_for_magnitude(mag);
            last = (i == len - 1);
            junk_time = {16'($urandom), 32'($urandom)};
            send_item(make_item(raw, $urandom_range(0, 15) != 0, last,
                                last ? stamp : junk_time));
        end
    endtask

    // Packet time: mostly forward, sometimes zero, backwards or anywhere
    task automatic step_clock_us();
        case ($urandom_range(0, 39))
            0: now_us = '0;
            1: now_us = now_us - $urandom_range(1, 3000);
            2: now_us = {16'($urandom), 32'($urandom)};
            3: now_us = 48'hFFFF_FFFF_F000 + $urandom_range(0, 4000);
            default: now_us = now_us + $urandom_range(50, 4000);
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65536;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_span();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 20000);
        endcase
    endfunction

    // Reset values, empty packet, s16 extremes
    task automatic test_reset_defaults();
        send_item(make_item(32'h0, 1'b0, 1'b1, 48'd1000));
        send_item(make_item(32'h0000_8000, 1'b1, 1'b1, 48'd2000));
        send_item(make_item(32'hFFFF_0000, 1'b1, 1'b1, 48'd3000));
        send_item(make_item(32'h0000_7FFF, 1'b1, 1'b0, 48'd3500));
        send_item(make_item(32'h1234_0001, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF));
        wait_idle();
    endtask

    // Extremes of the u8 and s32 formats, and the unknown format taking no samples
    task automatic test_sample_extremes();
        write_reg(REG_SAMPLE_FORMAT, FMT_U8);
        send_item(make_item(32'h0000_0000, 1'b1, 1'b0, 48'd0));
        send_item(make_item(32'hFFFF_FFFF, 1'b1, 1'b0, 48'd0));
        send_item(make_item(32'h0000_0080, 1'b1, 1'b1, 48'd4000));
        wait_idle();
        write_reg(REG_SAMPLE_FORMAT, FMT_S32);
        send_item(make_item(32'h8000_0000, 1'b1, 1'b0, 48'd0));
        send_item(make_item(32'h7FFF_FFFF, 1'b1, 1'b0, 48'd0));
        send_item(make_item(32'h0000_7FFF, 1'b1, 1'b1, 48'd5000));
        wait_idle();
        write_reg(REG_SAMPLE_FORMAT, FMT_NONE);
        send_item(make_item(32'hFFFF_FFFF, 1'b1, 1'b0, 48'd0));
        send_item(make_item(32'h8000_0000, 1'b1, 1'b1, 48'd6000));
        wait_idle();
    endtask

    // Start, update and end, silence count restarts, time running backwards
    task automatic test_hangover();
        write_reg(REG_SAMPLE_FORMAT, FMT_S16);
        write_reg(REG_START_THRESHOLD, 40000);
        write_reg(REG_STOP_THRESHOLD, 20000);
        write_reg(REG_MIN_SILENCE_TIME, 1000);
        write_reg(REG_UPDATE_INTERVAL, 500);
        send_item(make_item(32'd25000, 1'b1, 1'b1, 48'd100));
        send_item(make_item(32'd1000, 1'b1, 1'b1, 48'd0));
        send_item(make_item(32'd1000, 1'b1, 1'b1, 48'd300));
        send_item(make_item(32'd1000, 1'b1, 1'b1, 48'd200));
        send_item(make_item(32'd1000, 1'b1, 1'b1, 48'd1300));
        send_item(make_item(32'd15000, 1'b1, 1'b1, 48'd1400));
        send_item(make_item(32'd25000, 1'b1, 1'b1, 48'd1500));
        send_item(make_item(32'd25000, 1'b1, 1'b1, 48'd1700));
        send_item(make_item(32'd25000, 1'b1, 1'b1, 48'd2000));
        wait_idle();
        // Stop above start, and silence with no hangover
        write_reg(REG_START_THRESHOLD, 0);
        write_reg(REG_STOP_THRESHOLD, 30000);
        write_reg(REG_MIN_SILENCE_TIME, 0);
        send_item(make_item(32'd1000, 1'b1, 1'b1, 48'd2100));
        send_item(make_item(32'd20000, 1'b1, 1'b1, 48'd2200));
        send_item(make_item(32'd20000, 1'b1, 1'b1, 48'd2300));
        wait_idle();
    endtask

    // Writes past the last register change nothing
    task automatic test_register_index();
        for (int i = int'(REG_UPDATE_INTERVAL) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), $urandom);
        send_item(make_item(32'd32768, 1'b1, 1'b1, 48'd9000));
        send_item(make_item(32'd0, 1'b1, 1'b1, 48'd9100));
        wait_idle();
    endtask

    // Hold off the receiver while packets keep coming, then pause the sender
    task automatic test_backpressure();
        write_reg(REG_SAMPLE_FORMAT, FMT_S16);
        write_reg(REG_START_THRESHOLD, 0);
        write_reg(REG_STOP_THRESHOLD, 0);
        write_reg(REG_UPDATE_INTERVAL, 0);
        hold_cycles = 600;
        for (int i = 0; i < 40; i++)
        begin
            now_us = now_us + 100;
            send_packet($urandom_range(1, 3), 50000, 20000, 1'b0, now_us);
        end
        wait_idle();
    endtask

    // Samples past the packet cap must not reach level or peak
    task automatic test_long_packet();
        gaps_on = 1'b0;
        for (int i = 0; i < MAX_PACKET_SAMPLES; i++)
            send_item(make_item(raw_for_magnitude($urandom_range(0, 2000)), 1'b1, 1'b0,
                                48'd0));
        for (int i = 0; i < 20; i++)
            send_item(make_item(32'h0000_8000, 1'b1, 1'b0, 48'd0));
        now_us = now_us + 1000;
        send_item(make_item(32'h0000_8000, 1'b1, 1'b1, now_us));
        wait_idle();
        gaps_on = 1'b1;
    endtask

    // Random configuration, then speech bursts alternating with silence
    task automatic run_random_phase();
        int loud;
        int quiet;
        int gate;
        int unsigned len;
        wait_idle();
        write_reg(REG_SAMPLE_FORMAT,
                  ($urandom_range(0, 9) == 0) ? FMT_NONE : FMT_W'($urandom_range(0, 2)));
        write_reg(REG_START_THRESHOLD, pick_threshold());
        write_reg(REG_STOP_THRESHOLD, pick_threshold());
        write_reg(REG_MIN_SILENCE_TIME, pick_span());
        write_reg(REG_UPDATE_INTERVAL, pick_span());
        gaps_on = ($urandom_range(0, 3) != 0);
        gate = (cfg_start > cfg_stop) ? int'(cfg_start) : int'(cfg_stop);
        repeat ($urandom_range(8, 20))
        begin
            loud = $urandom_range(gate, 65536);
            quiet = (cfg_stop > 0) ? $urandom_range(0, cfg_stop - 1) : 0;
            for (int p = $urandom_range(2, 11); p > 0; p--)
            begin
                step_clock_us();
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
                send_packet(len, (p > 6) ? quiet : loud, $urandom_range(0, 4096),
                            $urandom_range(0, 11) == 0, now_us);
            end
        end
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
            run_random_phase();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples_ch.valid = 1'b0;
        samples_ch.data = '0;

        // Detector copy after reset
        cfg_format = FMT_S16;
        cfg_start = '0;
        cfg_stop = '0;
        cfg_silence = '0;
        cfg_update = '0;
        mag_total = '0;
        mag_peak = '0;
        mag_count = 0;
        speaking = 1'b0;
        quiet_since = '0;
        last_report = '0;
        packets_ended = '0;
        events_made = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_reset_defaults();
        test_sample_extremes();
        test_hangover();
        test_register_index();
        test_backpressure();
        test_long_packet();
        test_random_traffic();
        wait_idle();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/evad_pkg.sv
hw/rtl/evad_in_if.sv
hw/rtl/evad_out_if.sv
hw/rtl/evad_front.sv
hw/rtl/evad_div.sv
hw/rtl/energy_voice_activity_detector.sv
tb/energy_voice_activity_detector_tb.sv
